FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the sprite list expander RTL.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define SLE_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Antecedent at one edge implies the consequent at the same edge.
`define SLE_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define SLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/sle_pkg.sv
// Package for the sprite list expander: types, constants and the star speed table.
// No dependencies; used by every module of the block.
package sle_pkg;

	localparam int ENTRY_LIMIT = 92;
	localparam int CNT_W       = 7;
	localparam int QUEUE_DEPTH = 4;
	localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		FUNC_START  = 2'd0,
		FUNC_SPRITE = 2'd1,
		FUNC_END    = 2'd2,
		FUNC_UNUSED = 2'd3
	} func_t;

	localparam logic KIND_ENTRY   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic [7:0] CODE_STEP_WIDE = 8'd2;
	localparam logic [7:0] CODE_STEP_LOW  = 8'd3;
	localparam logic [7:0] CODE_STEP_DIAG = 8'd1;
	localparam logic [7:0] QUARTER_SIZE8  = 8'd16;

	// One classified item handed from front to back.
	typedef struct packed {
		logic                   kind;
		logic [3:0]             mask;   // base, right, lower, diagonal
		logic [CNT_W-1:0]       base;
		logic [7:0]             code;
		logic [7:0]             color;
		logic [7:0]             flags;
		logic signed [8:0]      x;
		logic signed [9:0]      y;
		logic [7:0]             scroll;
		logic [CNT_W-1:0]       total;
	} cmd_t;

	// Twice the star speed entry, modulo 256.
	function automatic logic [7:0] star_step(input logic [2:0] sel);
		logic [7:0] step;
		unique case (sel)
			3'd0: step = 8'hFE;
			3'd1: step = 8'hFC;
			3'd2: step = 8'hFA;
			3'd3: step = 8'h00;
			3'd4: step = 8'h06;
			3'd5: step = 8'h04;
			3'd6: step = 8'h02;
			default: step = 8'h00;
		endcase
		return step;
	endfunction

endpackage

FILE: rtl/core/sle_front.sv
// Front end: accepts items, culls sprite quarters, numbers entries, updates star scroll.
// Depends on sle_pkg; feeds sle_queue.
module sle_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          func,
	input  logic [7:0]          sprite_code,
	input  logic [7:0]          sprite_color,
	input  logic [7:0]          sprite_flags,
	input  logic [7:0]          x_byte,
	input  logic [7:0]          y_byte,
	input  logic                y_high,
	input  logic                hidden,
	input  logic [2:0]          star_speed_select,
	input  logic                accept,
	output logic                wr_en,
	output sle_pkg::cmd_t       wr_cmd
);
	import sle_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [7:0]       scroll_q;
	logic [8:0]       y9;
	logic             dw, dh, x_in, x_in_r, y_in, y_in_l;
	logic [3:0]       mask;
	logic [2:0]       n_ent;
	logic             take_rec;
	logic [7:0]       scroll_nxt;

	always_comb begin
		y9     = {y_high, y_byte};
		dw     = sprite_flags[3];
		dh     = sprite_flags[2];
		// Screen culls rewritten on the raw position values.
		x_in   = (x_byte != 8'd0) && (x_byte < 8'd240);
		x_in_r = x_byte < 8'd224;
		y_in   = (y9 > 9'd24) && (y9 < 9'd328);
		y_in_l = (y9 > 9'd8) && (y9 < 9'd312);
		mask[0] = !sprite_code[7] && y_in && x_in;
		mask[1] = dw && y_in && x_in_r;
		mask[2] = dh && y_in_l && x_in;
		mask[3] = dw && dh && y_in_l && x_in_r;
		n_ent   = 3'(mask[0]) + 3'(mask[1]) + 3'(mask[2]) + 3'(mask[3]);
		take_rec = (func_t'(func) == FUNC_SPRITE) && !hidden
			&& (count_q < CNT_W'(ENTRY_LIMIT)) && (mask != 4'd0);
		scroll_nxt = scroll_q + star_step(star_speed_select);

		wr_cmd.kind   = (func_t'(func) == FUNC_END) ? KIND_SUMMARY : KIND_ENTRY;
		wr_cmd.mask   = mask;
		wr_cmd.base   = count_q;
		wr_cmd.code   = sprite_code;
		wr_cmd.color  = sprite_color;
		wr_cmd.flags  = sprite_flags;
		wr_cmd.x      = $signed({1'b0, x_byte}) - 9'sd16;
		wr_cmd.y      = $signed({1'b0, y9}) - 10'sd40;
		wr_cmd.scroll = scroll_nxt;
		wr_cmd.total  = count_q;
		wr_en = accept && (take_rec || (func_t'(func) == FUNC_END));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			scroll_q <= '0;
		end else if (accept) begin
			unique case (func_t'(func))
				FUNC_START: count_q <= '0;
				FUNC_SPRITE: if (take_rec) begin
					count_q <= count_q + CNT_W'(n_ent);
				end
				FUNC_END: scroll_q <= scroll_nxt;
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/core/sle_queue.sv
// Short command queue between front and back of the sprite list expander.
// Depends on sle_pkg for the command type and depth.
module sle_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  sle_pkg::cmd_t       wr_cmd,
	input  logic                rd_en,
	output sle_pkg::cmd_t       rd_cmd,
	output logic                full,
	output logic                empty
);
	import sle_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QIDX_W-1:0] wp_q, rp_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_wr, do_rd;

	assign full   = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign empty  = cnt_q == '0;
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_cmd = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= wp_q + 1'b1;
			if (do_rd) rp_q <= rp_q + 1'b1;
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/sle_back.sv
// Back end: walks the quarter mask of the queue head into the output register, one
// entry per cycle while pop is high. Depends on sle_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sle_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sle_pkg::cmd_t           head,
	input  logic                    head_empty,
	output logic                    head_pop,
	input  logic                    pop,
	output logic                    empty,
	output logic                    kind,
	output logic [6:0]              entry_index,
	output logic [7:0]              entry_code,
	output logic [7:0]              entry_color,
	output logic [7:0]              entry_flags,
	output logic signed [8:0]       entry_x,
	output logic signed [9:0]       entry_y,
	output logic                    last,
	output logic [7:0]              star_scroll,
	output logic [6:0]              total_entries
);
	import sle_pkg::*;

	logic             out_valid_q;
	logic             started_q;
	logic [3:0]       rem_q;
	logic [CNT_W-1:0] idx_q;

	logic [3:0]        cur_mask, nxt_mask;
	logic [CNT_W-1:0]  cur_idx;
	logic              load, last_now;
	logic [7:0]        q_code;
	logic signed [8:0] q_x;
	logic signed [9:0] q_y;

	always_comb begin
		cur_mask = started_q ? rem_q : head.mask;
		cur_idx  = started_q ? idx_q : head.base;
		// Clear the lowest set bit: the quarter emitted now.
		nxt_mask = cur_mask & (cur_mask - 4'd1);
		last_now = (head.kind == KIND_SUMMARY) || (nxt_mask == 4'd0);
		q_code   = head.code;
		q_x      = head.x;
		q_y      = head.y;
		priority if (cur_mask[0]) begin
			q_code = head.flags[3] ? head.code + CODE_STEP_WIDE : head.code;
		end else if (cur_mask[1]) begin
			q_x = head.x + 9'sd16;
		end else if (cur_mask[2]) begin
			q_code = head.code + CODE_STEP_LOW;
			q_y    = head.y + 10'sd16;
		end else begin
			q_code = head.code + CODE_STEP_DIAG;
			q_x    = head.x + 9'sd16;
			q_y    = head.y + 10'sd16;
		end
		load     = (!out_valid_q || pop) && !head_empty;
		head_pop = load && last_now;
	end

	assign empty = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			started_q   <= 1'b0;
			rem_q       <= '0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				started_q   <= !last_now;
				rem_q       <= nxt_mask;
				idx_q       <= cur_idx + 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind <= head.kind;
			last <= last_now;
			if (head.kind == KIND_SUMMARY) begin
				entry_index   <= '0;
				entry_code    <= '0;
				entry_color   <= '0;
				entry_flags   <= '0;
				entry_x       <= '0;
				entry_y       <= '0;
				star_scroll   <= head.scroll;
				total_entries <= head.total;
			end else begin
				entry_index   <= cur_idx;
				entry_code    <= q_code;
				entry_color   <= head.color;
				entry_flags   <= head.flags;
				entry_x       <= q_x;
				entry_y       <= q_y;
				star_scroll   <= '0;
				total_entries <= '0;
			end
		end
	end

	`SLE_ASSERT_IMPLIES(a_walk_nonempty, started_q, rem_q != 4'd0, "walk with no quarter left")
	`SLE_ASSERT_IMPLIES(a_summary_last, out_valid_q && kind == KIND_SUMMARY, last,
		"summary not marked last")
	`SLE_ASSERT_IMPLIES(a_index_bound, out_valid_q && kind == KIND_ENTRY,
		entry_index < CNT_W'(ENTRY_LIMIT + 3), "entry index beyond list")
	`SLE_ASSERT_NEXT(a_walk_holds_head, started_q && head_empty, started_q,
		"walk state lost while head missing")

endmodule

FILE: rtl/core/sprite_list_expander.sv
// Sprite list expander: turns frame markers and sprite records into list entries.
// Usage and timing notes follow. Instantiates sle_front, sle_queue and sle_back.
//
// Input channel: drive func and the record fields with push high; the item is taken
// at a clock edge where push is high and full is low. Items may follow every cycle.
// Result channel: while empty is low the oldest result is on the output ports; it is
// taken at a clock edge where pop is high. last marks the final result of an item.
// A start-of-frame item clears the entry counter and gives no result; an end-of-frame
// item gives one summary result with the new star scroll and the entry total.
// A sprite record gives zero to four entries, one per cycle from the back end while
// the receiver pops, so a record with four visible quarters gives four results; the
// back end's one-entry-per-cycle walk sets the sustained rate. With the queue empty
// an accepted item is written into the queue, then into the output register.
// A four-deep queue separates the front, which classifies at one item per cycle, from
// the back; when the receiver stalls, the output register holds and the queue fills,
// then full rises. Reset clears the counter, the star scroll and the queue.
module sprite_list_expander (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        func,
	input  logic [7:0]        sprite_code,
	input  logic [7:0]        sprite_color,
	input  logic [7:0]        sprite_flags,
	input  logic [7:0]        x_byte,
	input  logic [7:0]        y_byte,
	input  logic              y_high,
	input  logic              hidden,
	input  logic [2:0]        star_speed_select,
	output logic              empty,
	input  logic              pop,
	output logic              kind,
	output logic [6:0]        entry_index,
	output logic [7:0]        entry_code,
	output logic [7:0]        entry_color,
	output logic [7:0]        entry_flags,
	output logic signed [8:0] entry_x,
	output logic signed [9:0] entry_y,
	output logic              last,
	output logic [7:0]        star_scroll,
	output logic [6:0]        total_entries
);
	import sle_pkg::*;

	cmd_t wr_cmd, head;
	logic wr_en, head_pop, head_empty, accept;

	assign accept = push && !full;

	sle_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.func              (func),
		.sprite_code       (sprite_code),
		.sprite_color      (sprite_color),
		.sprite_flags      (sprite_flags),
		.x_byte            (x_byte),
		.y_byte            (y_byte),
		.y_high            (y_high),
		.hidden            (hidden),
		.star_speed_select (star_speed_select),
		.accept            (accept),
		.wr_en             (wr_en),
		.wr_cmd            (wr_cmd)
	);

	sle_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.wr_cmd (wr_cmd),
		.rd_en  (head_pop),
		.rd_cmd (head),
		.full   (full),
		.empty  (head_empty)
	);

	sle_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_empty    (head_empty),
		.head_pop      (head_pop),
		.pop           (pop),
		.empty         (empty),
		.kind          (kind),
		.entry_index   (entry_index),
		.entry_code    (entry_code),
		.entry_color   (entry_color),
		.entry_flags   (entry_flags),
		.entry_x       (entry_x),
		.entry_y       (entry_y),
		.last          (last),
		.star_scroll   (star_scroll),
		.total_entries (total_entries)
	);

endmodule

FILE: bench/tb_sprite_list_expander.sv
`timescale 1ns / 1ps
// Self-checking bench for sprite_list_expander: queue-style driver and monitor.
// Predicts entries and frame summaries in SV; depends on sle_pkg and the block's RTL.
module tb_sprite_list_expander;
	import sle_pkg::*;

	localparam int RUN_LIMIT    = 200000;
	localparam int DRAIN_CYCLES = 20;
	localparam int LONG_HOLD    = 400;
	localparam int PHASE_ITEMS  = 45;
	localparam int X_BIAS       = 16;
	localparam int Y_BIAS       = 40;
	localparam int X_SCREEN     = 224;
	localparam int Y_SCREEN     = 288;
	localparam int CODE_LIMIT   = 128;
	localparam int STAR_SPEED[8] = '{-1, -2, -3, 0, 3, 2, 1, 0};

	typedef struct {
		func_t      func;
		logic [7:0] code;
		logic [7:0] color;
		logic [7:0] flags;
		logic [7:0] xb;
		logic [7:0] yb;
		logic       yh;
		logic       hid;
		logic [2:0] speed;
	} sprite_item_t;

	typedef struct {
		logic              kind;
		logic [6:0]        index;
		logic [7:0]        code;
		logic [7:0]        color;
		logic [7:0]        flags;
		logic signed [8:0] x;
		logic signed [9:0] y;
		logic              last;
		logic [7:0]        scroll;
		logic [6:0]        total;
	} list_entry_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic [1:0]        func = FUNC_START;
	logic [7:0]        sprite_code = '0;
	logic [7:0]        sprite_color = '0;
	logic [7:0]        sprite_flags = '0;
	logic [7:0]        x_byte = '0;
	logic [7:0]        y_byte = '0;
	logic              y_high = 1'b0;
	logic              hidden = 1'b0;
	logic [2:0]        star_speed_select = '0;
	logic              empty;
	logic              pop = 1'b0;
	logic              kind;
	logic [6:0]        entry_index;
	logic [7:0]        entry_code;
	logic [7:0]        entry_color;
	logic [7:0]        entry_flags;
	logic signed [8:0] entry_x;
	logic signed [9:0] entry_y;
	logic              last;
	logic [7:0]        star_scroll;
	logic [6:0]        total_entries;

	sprite_item_t record_feed[$];
	list_entry_t  pending_entries[$];
	sprite_item_t drive_item;
	int           frame_entry_count = 0;
	logic [7:0]   star_scroll_pos = '0;
	int           sender_idle_pct = 0;
	int           rx_stall_pct = 0;
	logic         long_hold_go = 1'b0;
	int           hold_cycles_left = 0;
	int           mismatches = 0;
	int           cycle_count = 0;

	sprite_list_expander u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .func(func),
		.sprite_code(sprite_code), .sprite_color(sprite_color), .sprite_flags(sprite_flags),
		.x_byte(x_byte), .y_byte(y_byte), .y_high(y_high), .hidden(hidden),
		.star_speed_select(star_speed_select), .empty(empty), .pop(pop), .kind(kind),
		.entry_index(entry_index), .entry_code(entry_code), .entry_color(entry_color),
		.entry_flags(entry_flags), .entry_x(entry_x), .entry_y(entry_y), .last(last),
		.star_scroll(star_scroll), .total_entries(total_entries)
	);

	always #5 clk = ~clk;

	function automatic sprite_item_t make_item(func_t f, logic [7:0] code, logic [7:0] color,
			logic [7:0] flags, logic [7:0] xb, logic [7:0] yb, logic yh, logic hid,
			logic [2:0] speed);
		sprite_item_t it;
		it.func = f;
		it.code = code;
		it.color = color;
		it.flags = flags;
		it.xb = xb;
		it.yb = yb;
		it.yh = yh;
		it.hid = hid;
		it.speed = speed;
		return it;
	endfunction

	function automatic void feed_item(func_t f, logic [7:0] code, logic [7:0] color,
			logic [7:0] flags, logic [7:0] xb, logic [7:0] yb, logic yh, logic hid,
			logic [2:0] speed);
		record_feed.push_back(make_item(f, code, color, flags, xb, yb, yh, hid, speed));
	endfunction

	// Random filler fields for markers and unused codes.
	function automatic sprite_item_t rand_fill(func_t f);
		return make_item(f, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)), 3'($urandom));
	endfunction

	function automatic void add_entry(logic [7:0] code, logic [7:0] color, logic [7:0] flags,
			int xs, int ys);
		list_entry_t e;
		e = '{default: '0};
		e.kind = KIND_ENTRY;
		e.index = frame_entry_count[6:0];
		e.code = code;
		e.color = color;
		e.flags = flags;
		e.x = xs[8:0];
		e.y = ys[9:0];
		pending_entries.push_back(e);
		frame_entry_count = (frame_entry_count + 1) & 8'h7F;
	endfunction

	// Work out the results of one accepted item and advance the frame state.
	function automatic void expand_item(sprite_item_t it);
		list_entry_t s;
		int xs, ys, n_prior, step;
		logic dw, dh, y_ok, yl_ok;
		n_prior = pending_entries.size();
		case (it.func)
			FUNC_START: frame_entry_count = 0;
			FUNC_END: begin
				step = star_scroll_pos + 2 * STAR_SPEED[it.speed];
				star_scroll_pos = step[7:0];
				s = '{default: '0};
				s.kind = KIND_SUMMARY;
				s.last = 1'b1;
				s.scroll = star_scroll_pos;
				s.total = frame_entry_count[6:0];
				pending_entries.push_back(s);
			end
			FUNC_SPRITE: begin
				if (!it.hid && frame_entry_count < ENTRY_LIMIT) begin
					xs = int'(it.xb) - X_BIAS;
					ys = int'(it.yb) + 256 * int'(it.yh) - Y_BIAS;
					dw = it.flags[3];
					dh = it.flags[2];
					y_ok = ys > -16 && ys < Y_SCREEN;
					yl_ok = ys + 16 > -16 && ys + 16 < Y_SCREEN;
					if (it.code < CODE_LIMIT && y_ok && xs > -16 && xs < X_SCREEN)
						add_entry(it.code + (dw ? 8'd2 : 8'd0), it.color, it.flags, xs, ys);
					if (dw && y_ok && xs + 16 >= -16 && xs + 16 < X_SCREEN)
						add_entry(it.code, it.color, it.flags, xs + 16, ys);
					if (dh && yl_ok && xs > -16 && xs < X_SCREEN)
						add_entry(it.code + 8'd3, it.color, it.flags, xs, ys + 16);
					if (dw && dh && yl_ok && xs + 16 > -16 && xs + 16 < X_SCREEN)
						add_entry(it.code + 8'd1, it.color, it.flags, xs + 16, ys + 16);
					if (pending_entries.size() > n_prior)
						pending_entries[pending_entries.size() - 1].last = 1'b1;
				end
			end
			default: ;
		endcase
	endfunction

	// Tidy records sit fully on screen; the rest are raw random bytes.
	function automatic sprite_item_t rand_record(bit tidy, bit quad);
		sprite_item_t it;
		it = rand_fill(FUNC_SPRITE);
		it.hid = ($urandom_range(7) == 0);
		if (tidy) begin
			it.hid = ($urandom_range(19) == 0);
			it.xb = 8'($urandom_range(223, 16));
			if ($urandom_range(3) == 0) begin
				it.yh = 1'b1;
				it.yb = 8'($urandom_range(31));
			end else begin
				it.yh = 1'b0;
				it.yb = 8'($urandom_range(255, 40));
			end
			if (quad || $urandom_range(9) < 6)
				it.flags[3:2] = 2'b11;
		end
		return it;
	endfunction

	// Queue one frame; return how many start, record and end items it holds.
	function automatic int queue_frame(bit long_frame);
		int nrec, counted;
		bit tidy;
		counted = 0;
		tidy = long_frame || ($urandom_range(5) != 0);
		if ($urandom_range(9) != 0) begin
			record_feed.push_back(rand_fill(FUNC_START));
			counted++;
		end
		nrec = long_frame ? $urandom_range(34, 26) : $urandom_range(12, 2);
		for (int i = 0; i < nrec; i++) begin
			record_feed.push_back(rand_record(tidy, long_frame));
			counted++;
			if ($urandom_range(19) == 0)
				record_feed.push_back(rand_fill(FUNC_UNUSED));
		end
		if ($urandom_range(9) != 0) begin
			record_feed.push_back(rand_fill(FUNC_END));
			counted++;
		end
		return counted;
	endfunction

	task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	task automatic wait_drained();
		while (record_feed.size() != 0 || push || pending_entries.size() != 0)
			@(negedge clk);
	endtask

	// Driver: hold the item while full, otherwise offer the next one or idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full)
				expand_item(drive_item);
			if (!push || !full) begin
				if (record_feed.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					drive_item = record_feed.pop_front();
					push <= 1'b1;
					func <= drive_item.func;
					sprite_code <= drive_item.code;
					sprite_color <= drive_item.color;
					sprite_flags <= drive_item.flags;
					x_byte <= drive_item.xb;
					y_byte <= drive_item.yb;
					y_high <= drive_item.yh;
					hidden <= drive_item.hid;
					star_speed_select <= drive_item.speed;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_cycles_left <= 0;
		else if (long_hold_go)
			hold_cycles_left <= LONG_HOLD;
		else if (hold_cycles_left != 0)
			hold_cycles_left <= hold_cycles_left - 1;
	end

	// Monitor: compare each popped result with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		list_entry_t w;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (pending_entries.size() == 0) begin
					$error("unexpected result: kind %0d index %0d", kind, entry_index);
					mismatches++;
				end else begin
					w = pending_entries.pop_front();
					check_field("kind", 32'(w.kind), 32'(kind));
					check_field("entry_index", 32'(w.index), 32'(entry_index));
					check_field("entry_code", 32'(w.code), 32'(entry_code));
					check_field("entry_color", 32'(w.color), 32'(entry_color));
					check_field("entry_flags", 32'(w.flags), 32'(entry_flags));
					check_field("entry_x", 32'(w.x), 32'(entry_x));
					check_field("entry_y", 32'(w.y), 32'(entry_y));
					check_field("last", 32'(w.last), 32'(last));
					check_field("star_scroll", 32'(w.scroll), 32'(star_scroll));
					check_field("total_entries", 32'(w.total), 32'(total_entries));
				end
			end
			pop <= (hold_cycles_left == 0) && ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("sprite_list_expander: mismatch");
			$finish;
		end
	end

	initial begin
		int sent;
		int idle_pct[4];
		int stall_pct[4];
		idle_pct = '{0, 63, 0, 14};
		stall_pct = '{0, 0, 63, 14};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: screen edges, culls, code wrap, hidden, unused code, ends.
		feed_item(FUNC_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 3'd0);
		feed_item(FUNC_SPRITE, 8'h00, 8'h00, 8'h00, 8'd16, 8'd40, 1'b0, 1'b0, 3'd0);
		feed_item(FUNC_SPRITE, 8'h7F, 8'hFF, 8'h0C, 8'd0, 8'd0, 1'b0, 1'b0, 3'd7);
		feed_item(FUNC_SPRITE, 8'hFF, 8'h5A, 8'h0C, 8'hFF, 8'hFF, 1'b1, 1'b0, 3'd0);
		feed_item(FUNC_SPRITE, 8'h7F, 8'hA5, 8'hFF, 8'd100, 8'd100, 1'b0, 1'b0, 3'd0);
		feed_item(FUNC_SPRITE, 8'hFE, 8'h3C, 8'h0C, 8'd120, 8'd150, 1'b0, 1'b0, 3'd0);
		feed_item(FUNC_SPRITE, 8'h10, 8'h11, 8'h0C, 8'd100, 8'd100, 1'b0, 1'b1, 3'd0);
		feed_item(FUNC_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 3'd7);
		feed_item(FUNC_SPRITE, 8'h20, 8'h01, 8'h0C, 8'd1, 8'd25, 1'b0, 1'b0, 3'd0);
		feed_item(FUNC_SPRITE, 8'h21, 8'h02, 8'h0C, 8'd0, 8'd24, 1'b0, 1'b0, 3'd0);
		feed_item(FUNC_SPRITE, 8'h22, 8'h03, 8'h0C, 8'd239, 8'd71, 1'b1, 1'b0, 3'd0);
		feed_item(FUNC_SPRITE, 8'h23, 8'h04, 8'h08, 8'd240, 8'd72, 1'b1, 1'b0, 3'd0);
		feed_item(FUNC_SPRITE, 8'h24, 8'h05, 8'h0C, 8'd223, 8'd80, 1'b0, 1'b0, 3'd0);
		feed_item(FUNC_SPRITE, 8'h25, 8'h06, 8'h0C, 8'd224, 8'd80, 1'b0, 1'b0, 3'd0);
		feed_item(FUNC_END, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 3'd0);
		feed_item(FUNC_END, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 3'd4);
		feed_item(FUNC_END, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 3'd7);
		feed_item(FUNC_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 3'd0);
		feed_item(FUNC_SPRITE, 8'h40, 8'h80, 8'h08, 8'd50, 8'd60, 1'b0, 1'b0, 3'd0);
		feed_item(FUNC_SPRITE, 8'h41, 8'h81, 8'h04, 8'd50, 8'd60, 1'b0, 1'b0, 3'd0);
		feed_item(FUNC_END, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 3'd3);
		wait_drained();

		// Random frames; the first frame of each phase runs the list full.
		for (int phase = 0; phase < 4; phase++) begin
			sender_idle_pct = idle_pct[phase];
			rx_stall_pct = stall_pct[phase];
			sent = queue_frame(1'b1);
			while (sent < PHASE_ITEMS)
				sent += queue_frame($urandom_range(3) == 0);
			if (phase == 0) begin
				long_hold_go = 1'b1;
				@(negedge clk);
				long_hold_go = 1'b0;
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("sprite_list_expander: match");
		else
			$display("sprite_list_expander: mismatch");
		$finish;
	end

endmodule
